/* rtl/iar_pkg.sv */
// ----------------------------------------------------------------------------
// iar_pkg
// Types, constants and the digit-to-character function shared by the radix text encoder.
// ----------------------------------------------------------------------------
package iar_pkg;

	typedef struct packed {
		logic [63:0] value;
		logic [4:0]  base;
		logic        is_signed;
		logic        upper_case;
	} iar_req_t;

	typedef struct packed {
		logic [6:0] character;
		logic       last;
		logic [6:0] char_total;
		logic       overflow;
	} iar_rsp_t;

	typedef struct packed {
		logic [4:0] base;
		logic       neg;
		logic       upper;
		logic       ovf;
	} iar_ctl_t;

	localparam logic [4:0] BASE_MIN = 5'd2;
	localparam logic [4:0] BASE_MAX = 5'd16;
	localparam logic [6:0] CHAR_MINUS = 7'h2D;
	localparam logic [6:0] CHAR_ZERO = 7'h30;
	localparam logic [6:0] CHAR_UPPER_OFS = 7'h37;
	localparam logic [6:0] CHAR_LOWER_OFS = 7'h57;
	localparam logic [3:0] DIGIT_TEN = 4'd10;
	localparam int STEP_BITS = 8;

	function automatic logic [6:0] digit_char(logic [3:0] digit, logic upper);
		logic [6:0] code;
		if (digit < DIGIT_TEN) begin
			code = CHAR_ZERO + {3'b000, digit};
		end else if (upper) begin
			code = CHAR_UPPER_OFS + {3'b000, digit};
		end else begin
			code = CHAR_LOWER_OFS + {3'b000, digit};
		end
		return code;
	endfunction

endpackage

/* rtl/iar_ram.sv */
// ----------------------------------------------------------------------------
// iar_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iar_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/iar_front.sv */
// ----------------------------------------------------------------------------
// iar_front
// Accepts request items, clamps the base, detects the sign and the most
// negative value, and forms the magnitude to be converted.
// ----------------------------------------------------------------------------
module iar_front
	import iar_pkg::*;
#(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                   req_valid,
	output logic                   req_ready,
	input  iar_req_t               req,
	output logic                   push_valid,
	input  logic                   push_ready,
	output iar_ctl_t               push_ctl,
	output logic [VALUE_WIDTH-1:0] push_mag
);

	localparam logic [VALUE_WIDTH-1:0] SIGN_ONLY = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	logic [VALUE_WIDTH-1:0] raw;
	logic                   sign;
	logic                   most_neg;

	always_comb begin
		raw = req.value[VALUE_WIDTH-1:0];
		sign = req.is_signed & raw[VALUE_WIDTH-1];
		most_neg = sign && (raw == SIGN_ONLY);
		push_ctl.ovf = most_neg;
		push_ctl.neg = sign & ~most_neg;
		push_ctl.upper = req.upper_case;
		if (req.base < BASE_MIN) begin
			push_ctl.base = BASE_MIN;
		end else if (req.base > BASE_MAX) begin
			push_ctl.base = BASE_MAX;
		end else begin
			push_ctl.base = req.base;
		end
		push_mag = sign ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;
	end

	assign push_valid = req_valid;
	assign req_ready = push_ready;

endmodule

/* rtl/iar_queue.sv */
// ----------------------------------------------------------------------------
// iar_queue
// Two-entry queue that decouples the classifier from the converter.
// ----------------------------------------------------------------------------
module iar_queue #(
	parameter int WIDTH = 72
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam logic [1:0] FULL = 2'd2;

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != FULL);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data = entry_q[rd_ptr_q];
	assign push = push_valid & push_ready;
	assign pop = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL)
		else $error("queue count beyond its depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == FULL) |-> (wr_ptr_q == rd_ptr_q))
		else $error("full queue with mismatched pointers");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with mismatched pointers");

endmodule

/* rtl/iar_back.sv */
// ----------------------------------------------------------------------------
// iar_back
// Converts one magnitude into digits by repeated division by the base,
// eight dividend bits per cycle, stores the digits and replays them most
// significant first through the result register.
// ----------------------------------------------------------------------------
module iar_back
	import iar_pkg::*;
#(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	output logic                   pop_ready,
	input  iar_ctl_t               pop_ctl,
	input  logic [VALUE_WIDTH-1:0] pop_mag,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output iar_rsp_t               rsp
);

	localparam int CHUNKS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD_W = CHUNKS * STEP_BITS;
	localparam int CHK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int ADDR_W = $clog2(VALUE_WIDTH);
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam logic [CHK_W-1:0] LAST_CHUNK = CHK_W'(CHUNKS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_RD,
		ST_WR,
		ST_OVF
	} state_t;

	state_t            state_q;
	iar_ctl_t          ctl_q;
	logic [PAD_W-1:0]  div_q;
	logic [3:0]        rem_q;
	logic [CHK_W-1:0]  chunk_q;
	logic [CNT_W-1:0]  nd_q;
	logic [ADDR_W-1:0] rd_idx_q;
	logic [6:0]        total_q;
	logic              rsp_valid_q;
	iar_rsp_t          rsp_q;

	logic [PAD_W-1:0]     div_next;
	logic [3:0]           rem_next;
	logic [STEP_BITS-1:0] qbits;
	logic                 last_chunk;
	logic                 ram_we;
	logic [3:0]           ram_rdata;
	logic                 slot_free;
	logic                 load_rsp;
	iar_rsp_t             rsp_next;

	always_comb begin
		logic [4:0] trial;
		logic [3:0] r;
		r = rem_q;
		qbits = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			trial = {r, div_q[PAD_W-1-i]};
			if (trial >= ctl_q.base) begin
				trial = trial - ctl_q.base;
				qbits[STEP_BITS-1-i] = 1'b1;
			end
			r = trial[3:0];
		end
		rem_next = r;
		div_next = (div_q << STEP_BITS) | PAD_W'(qbits);
	end

	assign last_chunk = (chunk_q == LAST_CHUNK);
	assign ram_we = (state_q == ST_DIV) && last_chunk;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign pop_ready = (state_q == ST_IDLE);

	iar_ram #(
		.WIDTH(4),
		.DEPTH(VALUE_WIDTH)
	) u_digits (
		.clk  (clk),
		.we   (ram_we),
		.waddr(nd_q[ADDR_W-1:0]),
		.wdata(rem_next),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		rsp_next = '0;
		load_rsp = 1'b0;
		case (state_q)
			ST_SIGN: begin
				rsp_next.character = CHAR_MINUS;
				load_rsp = slot_free;
			end
			ST_WR: begin
				rsp_next.character = digit_char(ram_rdata, ctl_q.upper);
				rsp_next.last = (rd_idx_q == '0);
				rsp_next.char_total = (rd_idx_q == '0) ? total_q : 7'd0;
				load_rsp = slot_free;
			end
			ST_OVF: begin
				rsp_next.last = 1'b1;
				rsp_next.overflow = 1'b1;
				load_rsp = slot_free;
			end
			default: begin
				load_rsp = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ctl_q <= '0;
			div_q <= '0;
			rem_q <= '0;
			chunk_q <= '0;
			nd_q <= '0;
			rd_idx_q <= '0;
			total_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
				rsp_q <= rsp_next;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						ctl_q <= pop_ctl;
						div_q <= PAD_W'(pop_mag);
						rem_q <= '0;
						chunk_q <= '0;
						nd_q <= '0;
						state_q <= pop_ctl.ovf ? ST_OVF : ST_DIV;
					end
				end
				ST_DIV: begin
					div_q <= div_next;
					if (!last_chunk) begin
						rem_q <= rem_next;
						chunk_q <= chunk_q + CHK_W'(1);
					end else begin
						rem_q <= '0;
						chunk_q <= '0;
						nd_q <= nd_q + CNT_W'(1);
						if (div_next == '0) begin
							rd_idx_q <= nd_q[ADDR_W-1:0];
							total_q <= 7'(nd_q) + 7'd1 + {6'd0, ctl_q.neg};
							state_q <= ctl_q.neg ? ST_SIGN : ST_RD;
						end
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (slot_free) begin
						if (rd_idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q - ADDR_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				ST_OVF: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (nd_q < CNT_W'(VALUE_WIDTH)))
		else $error("digit count ran past the value width");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> ($past(state_q) == ST_RD || $past(state_q) == ST_WR))
		else $error("digit emitted without a preceding read");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIGN) |-> ctl_q.neg)
		else $error("minus sign for a non-negative item");

endmodule

/* rtl/integer_to_ascii_radix_unit.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_unit
// Emits the ASCII text of a value in a base from 2 to 16, one character per
// result item, most significant digit first.
// ----------------------------------------------------------------------------
// Each request item is classified on acceptance and waits in a two-entry
// queue, so up to two further items are taken while one is being converted.
// The converter divides by the base eight bits per cycle, one digit per pass
// over the whole magnitude, and then replays the stored digits through the
// result register, one digit memory read per character, waiting while the
// previous result is not yet taken. A new item leaves the queue only after
// the last character of the previous one has been loaded.
// The most negative signed value yields one item with overflow set.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_unit
	import iar_pkg::*;
#(
	parameter int VALUE_WIDTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  iar_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output iar_rsp_t rsp
);

	localparam int CTL_W = $bits(iar_ctl_t);
	localparam int QW = CTL_W + VALUE_WIDTH;

	logic                   push_valid;
	logic                   push_ready;
	iar_ctl_t               push_ctl;
	logic [VALUE_WIDTH-1:0] push_mag;
	logic                   pop_valid;
	logic                   pop_ready;
	logic [QW-1:0]          pop_data;
	iar_ctl_t               pop_ctl;
	logic [VALUE_WIDTH-1:0] pop_mag;

	iar_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_ctl  (push_ctl),
		.push_mag  (push_mag)
	);

	iar_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data ({push_ctl, push_mag}),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	assign pop_ctl = iar_ctl_t'(pop_data[QW-1:VALUE_WIDTH]);
	assign pop_mag = pop_data[VALUE_WIDTH-1:0];

	iar_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_ctl  (pop_ctl),
		.pop_mag  (pop_mag),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule
